/* hdl/slcs_pkg.sv */
// shared types and constants of the sync/length/command/sum frame parser
// used by every module of the block; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package slcs_pkg;

  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned MaxPayload = 512;
  localparam int unsigned ResultCap  = 512;
  localparam int unsigned LimCap     = (MaxPayload < ResultCap) ? MaxPayload : ResultCap;
  localparam int unsigned AW         = $clog2(StoreDepth);
  localparam int unsigned CW         = AW + 1;
  localparam int unsigned Overhead   = 7;
  localparam int unsigned HdrBytes   = 6;
  localparam int unsigned ChunkBytes = 8;
  localparam int unsigned FifoDepth  = 2;

  localparam logic [15:0] SyncWord        = 16'h55AA;
  localparam logic [9:0]  MaxPayloadReset = 10'd512;
  localparam logic        RegMaxPayload   = 1'b0;
  localparam logic        KindAppend      = 1'b0;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [15:0] command;
    logic [9:0]  payload_length;
    logic [63:0] chunk;
    logic [3:0]  chunk_bytes;
    logic        last_chunk;
    logic        more_pending;
  } out_t;

  typedef struct packed {
    logic valid;
    in_t  item;
  } q_head_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_HUNT = 7'b0000010,
    S_HDR  = 7'b0000100,
    S_CHK  = 7'b0001000,
    S_SUM  = 7'b0010000,
    S_PLD  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

endpackage
`default_nettype wire

/* hdl/sync_len_cmd_sum_deframer.sv */
// an item is processed in steps: header reads at each hunt position tried, the sum check over
// the payload and sum byte, then reading and emitting each chunk; a result may wait for out_ready_i;
// the engine takes one queued item at a time while the front queue can accept more;
// the 1024-byte store has a single read port
// reset: store empty, max_payload 512; store contents are not cleared, no clearing pass
// top level: apb register, input queue, parser engine; depends on slcs_pkg
`timescale 1ns / 1ps
`default_nettype none
module sync_len_cmd_sum_deframer (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire slcs_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output slcs_pkg::out_t       out_data_o,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire [2:0]            paddr,
  input  wire [31:0]           pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [9:0]          maxp_q;
  logic [9:0]          lim;
  logic                pop;
  slcs_pkg::q_head_t   qhead;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == slcs_pkg::RegMaxPayload) ? {22'b0, maxp_q} : 32'b0;
  assign lim = (maxp_q > 10'(slcs_pkg::LimCap)) ? 10'(slcs_pkg::LimCap) : maxp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxp_q <= slcs_pkg::MaxPayloadReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == slcs_pkg::RegMaxPayload) begin
      maxp_q <= pwdata[9:0];
    end
  end

  slcs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .head_o     (qhead),
    .pop_i      (pop)
  );

  slcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (qhead),
    .pop_o       (pop),
    .lim_i       (lim),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_bytes_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.chunk_bytes <= 4'd8)
    else $error("chunk byte count above eight");
  a_full_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_chunk |-> out_data_o.chunk_bytes == 4'd8)
    else $error("partial chunk before the last one");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.chunk_bytes == 4'd0 |->
      out_data_o.payload_length == 10'd0 && out_data_o.last_chunk)
    else $error("empty chunk on a frame with payload");
`endif

endmodule
`default_nettype wire

/* hdl/slcs_front.sv */
// front end: accepts input transactions into a short queue for the parser
// depends on slcs_pkg
`timescale 1ns / 1ps
`default_nettype none
module slcs_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire slcs_pkg::in_t    in_data_i,
  output slcs_pkg::q_head_t     head_o,
  input  wire                   pop_i
);

  localparam int unsigned PW = $clog2(slcs_pkg::FifoDepth);

  slcs_pkg::in_t      ff_q [slcs_pkg::FifoDepth];
  logic [PW-1:0]      wp_q, wp_d, rp_q, rp_d;
  logic [PW:0]        cnt_q, cnt_d;
  logic               push;

  assign in_ready_o = (cnt_q != (PW+1)'(slcs_pkg::FifoDepth));
  assign push       = in_valid_i && in_ready_o;
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = ff_q[rp_q];

  always_comb begin
    wp_d  = push ? wp_q + 1'b1 : wp_q;
    rp_d  = pop_i ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (PW+1)'(push) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ff_q[wp_q] <= in_data_i;
    end
  end

endmodule
`default_nettype wire

/* hdl/slcs_back.sv */
// back end: byte store, frame hunt, checksum and chunked result output
// depends on slcs_pkg
`timescale 1ns / 1ps
`default_nettype none
module slcs_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire slcs_pkg::q_head_t head_i,
  output logic                  pop_o,
  input  wire [9:0]             lim_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output slcs_pkg::out_t        out_data_o
);

  localparam int unsigned AW = slcs_pkg::AW;
  localparam int unsigned CW = slcs_pkg::CW;

  logic [7:0]            mem [slcs_pkg::StoreDepth];
  logic [7:0]            rdata_q;
  logic                  re, we;
  logic [AW-1:0]         raddr, waddr;
  logic [CW-1:0]         rd_off;

  slcs_pkg::state_e      state_q, state_d;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d, sstart_q, sstart_d, p_q, p_d;
  logic [CW-1:0]         ic_q, ic_d, rc_q, rc_d, n_q, n_d, base_q, base_d;
  logic                  rvld_q, rvld_d, more_q, more_d;
  logic [47:0]           hdr_q, hdr_d;
  logic [7:0]            sum_q, sum_d;
  logic [63:0]           word_q, word_d;
  logic [3:0]            cb_q, cb_d;
  logic                  ov_q, ov_d;
  slcs_pkg::out_t        od_q, od_d;

  logic [CW-1:0]         left, drop, cnt_tmp, dlen_c, flen_c, rem;
  logic [15:0]           dlen;
  logic [16:0]           flen17;
  logic [7:0]            hsum;
  logic [3:0]            nb;
  logic                  slot_free, last_c;

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign raddr = head_q + rd_off[AW-1:0];

  always_comb begin
    left   = count_q - p_q;
    dlen   = hdr_q[31:16];
    flen17 = {1'b0, dlen} + 17'(slcs_pkg::Overhead);
    dlen_c = dlen[CW-1:0];
    flen_c = flen17[CW-1:0];
    hsum   = hdr_q[47:40] + hdr_q[39:32] + hdr_q[31:24] + hdr_q[23:16]
           + hdr_q[15:8] + hdr_q[7:0];
    rem    = dlen_c - base_q;
    nb     = (rem > CW'(slcs_pkg::ChunkBytes)) ? 4'(slcs_pkg::ChunkBytes) : rem[3:0];
    last_c = (base_q + CW'(slcs_pkg::ChunkBytes)) >= dlen_c;
    drop   = (sstart_q <= count_q) ? sstart_q : count_q;
    cnt_tmp = count_q - drop;
    slot_free = !ov_q || out_ready_i;
  end

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    count_d = count_q;
    sstart_d = sstart_q;
    p_d     = p_q;
    ic_d    = ic_q;
    rc_d    = rc_q;
    n_d     = n_q;
    base_d  = base_q;
    more_d  = more_q;
    hdr_d   = hdr_q;
    sum_d   = sum_q;
    word_d  = word_q;
    cb_d    = cb_q;
    od_d    = od_q;
    ov_d    = ov_q && !out_ready_i;
    pop_o   = 1'b0;
    re      = 1'b0;
    we      = 1'b0;
    rd_off  = '0;
    waddr   = head_q + count_q[AW-1:0];

    case (state_q)
      slcs_pkg::S_IDLE: begin
        if (head_i.valid) begin
          pop_o    = 1'b1;
          head_d   = head_q + drop[AW-1:0];
          count_d  = cnt_tmp;
          sstart_d = '0;
          p_d      = '0;
          if (head_i.item.kind == slcs_pkg::KindAppend &&
              cnt_tmp < CW'(slcs_pkg::StoreDepth)) begin
            we      = 1'b1;
            count_d = cnt_tmp + 1'b1;
          end
          state_d = slcs_pkg::S_HUNT;
        end
      end
      slcs_pkg::S_HUNT: begin
        if (left < CW'(slcs_pkg::Overhead)) begin
          head_d  = head_q + p_q[AW-1:0];
          count_d = left;
          state_d = slcs_pkg::S_IDLE;
        end else begin
          ic_d    = '0;
          rc_d    = '0;
          state_d = slcs_pkg::S_HDR;
        end
      end
      slcs_pkg::S_HDR: begin
        if (ic_q < CW'(slcs_pkg::HdrBytes)) begin
          re     = 1'b1;
          rd_off = p_q + ic_q;
          ic_d   = ic_q + 1'b1;
        end
        if (rvld_q) begin
          hdr_d = {hdr_q[39:0], rdata_q};
          rc_d  = rc_q + 1'b1;
          if (rc_q == CW'(slcs_pkg::HdrBytes - 1)) begin
            state_d = slcs_pkg::S_CHK;
          end
        end
      end
      slcs_pkg::S_CHK: begin
        if (hdr_q[47:32] != slcs_pkg::SyncWord || dlen > {6'b0, lim_i} ||
            flen17 > 17'(slcs_pkg::StoreDepth)) begin
          p_d     = p_q + 1'b1;
          state_d = slcs_pkg::S_HUNT;
        end else if ({6'b0, left} < flen17) begin
          head_d  = head_q + p_q[AW-1:0];
          count_d = left;
          state_d = slcs_pkg::S_IDLE;
        end else begin
          sum_d   = hsum;
          ic_d    = '0;
          rc_d    = '0;
          n_d     = dlen_c + 1'b1;
          state_d = slcs_pkg::S_SUM;
        end
      end
      slcs_pkg::S_SUM: begin
        if (ic_q < n_q) begin
          re     = 1'b1;
          rd_off = p_q + CW'(slcs_pkg::HdrBytes) + ic_q;
          ic_d   = ic_q + 1'b1;
        end
        if (rvld_q) begin
          rc_d = rc_q + 1'b1;
          if (rc_q == n_q - 1'b1) begin
            if (rdata_q == sum_q) begin
              more_d  = (p_q + flen_c) < count_q;
              ic_d    = '0;
              base_d  = '0;
              cb_d    = '0;
              word_d  = '0;
              state_d = slcs_pkg::S_PLD;
            end else begin
              p_d     = p_q + 1'b1;
              state_d = slcs_pkg::S_HUNT;
            end
          end else begin
            sum_d = sum_q + rdata_q;
          end
        end
      end
      slcs_pkg::S_PLD: begin
        if (nb == '0) begin
          state_d = slcs_pkg::S_OUT;
        end else begin
          if (ic_q < base_q + CW'(nb)) begin
            re     = 1'b1;
            rd_off = p_q + CW'(slcs_pkg::HdrBytes) + ic_q;
            ic_d   = ic_q + 1'b1;
          end
          if (rvld_q) begin
            word_d[cb_q[2:0]*8 +: 8] = rdata_q;
            cb_d = cb_q + 1'b1;
            if (cb_q + 1'b1 == nb) begin
              state_d = slcs_pkg::S_OUT;
            end
          end
        end
      end
      slcs_pkg::S_OUT: begin
        if (slot_free) begin
          ov_d = 1'b1;
          od_d.command        = hdr_q[15:0];
          od_d.payload_length = dlen[9:0];
          od_d.chunk          = word_q;
          od_d.chunk_bytes    = nb;
          od_d.last_chunk     = last_c;
          od_d.more_pending   = more_q;
          if (last_c) begin
            if (more_q) begin
              sstart_d = p_q + flen_c;
            end else begin
              count_d  = '0;
              sstart_d = '0;
            end
            state_d = slcs_pkg::S_IDLE;
          end else begin
            base_d  = base_q + CW'(slcs_pkg::ChunkBytes);
            cb_d    = '0;
            word_d  = '0;
            state_d = slcs_pkg::S_PLD;
          end
        end
      end
      default: begin
        state_d = slcs_pkg::S_IDLE;
      end
    endcase
    rvld_d = re;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= slcs_pkg::S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      sstart_q <= '0;
      rvld_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      sstart_q <= sstart_d;
      rvld_q   <= rvld_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    ic_q   <= ic_d;
    rc_q   <= rc_d;
    n_q    <= n_d;
    base_q <= base_d;
    more_q <= more_d;
    hdr_q  <= hdr_d;
    sum_q  <= sum_d;
    word_q <= word_d;
    cb_q   <= cb_d;
    od_q   <= od_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= head_i.item.data_byte;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
